FILE: design/bntt_pkg.sv
// ----------------------------------------------------------------------------
// bntt_pkg
// Shared types and constants for the block number translation table: word
// layouts of both channels, operation and status codes, default sizing.
// ----------------------------------------------------------------------------
package bntt_pkg;

    localparam int NUM_W   = 10;
    localparam int OFF_W   = 48;
    localparam int LEN_W   = 32;
    localparam int BYTES_W = 15;

    // default sizing of the table
    localparam int DEF_TABLE_ENTRIES  = 1024;
    localparam int DEF_RESERVED_COUNT = 3;

    // serialised size: header, footer and checksum bytes, and log2 of bytes per number
    localparam int BYTES_BASE      = 20;
    localparam int BYTES_PER_SHIFT = 4;

    // offset reported by a lookup of a number without a disk extent
    localparam logic [OFF_W-1:0] NO_DISK_MARK = {{(OFF_W-1){1'b1}}, 1'b0};

    typedef enum logic [1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_SET    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_INVALID   = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [NUM_W-1:0]   block_number;
        logic [OFF_W-1:0]   location;
        logic [LEN_W-1:0]   length;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [NUM_W-1:0]   given_number;
        logic [OFF_W-1:0]   found_location;
        logic [LEN_W-1:0]   found_length;
        logic               release_valid;
        logic [OFF_W-1:0]   release_location;
        logic [BYTES_W-1:0] table_bytes;
    } rsp_t;

endpackage

FILE: design/block_number_translation_table.sv
// ----------------------------------------------------------------------------
// block_number_translation_table
// Maps logical block numbers to disk extents, with a linked free list of
// released numbers kept in the same single-port table memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request word (allocate, free, lookup or
//   set location); m_valid/m_ready/m_data carry exactly one response word per
//   request, in request order.
//   Each request has a read step, which reads its table entry (for allocate,
//   the entry at the free-list head or the next never-used number), and an
//   execute step, which computes the response and writes the entry back. The
//   single table memory port sets this: a new request is taken only in the
//   idle state, so not before the last one has left execute, and the response
//   is loaded into the output register when execute ends, once that is free.
//   The output register lets the next request be accepted while a response
//   still waits; if the receiver keeps stalling, the block holds that second
//   request in its execute step until the output register frees.
//   Reset (aresetn low, synchronous) empties the free list and restarts the
//   never-used count at the reserved count; the memory itself needs no
//   clearing, since contents of entries at or above the never-used count are
//   never used and reserved entries are decoded as allocated without an extent.
// ----------------------------------------------------------------------------
module block_number_translation_table #(
    parameter int TABLE_ENTRIES  = bntt_pkg::DEF_TABLE_ENTRIES,
    parameter int RESERVED_COUNT = bntt_pkg::DEF_RESERVED_COUNT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bntt_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output bntt_pkg::rsp_t  m_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int PTR_W = IDX_W + 1;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(TABLE_ENTRIES);

    typedef struct packed {
        logic                         free;
        logic                         has_disk;
        logic [bntt_pkg::OFF_W-1:0]   offset;
        logic [bntt_pkg::LEN_W-1:0]   length;
        logic [PTR_W-1:0]             next_free;
    } entry_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t              state_reg;
    logic                m_valid_reg;
    bntt_pkg::rsp_t      m_data_reg;
    logic [PTR_W-1:0]    free_head_reg, free_head_next;
    logic [PTR_W-1:0]    nun_reg, nun_next;

    bntt_pkg::req_t      req_reg;
    logic [IDX_W-1:0]    addr_reg;

    entry_t              mem [TABLE_ENTRIES];
    entry_t              rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                rd_en;
    logic                wr_en;
    entry_t              wr_data;

    entry_t              cur;
    bntt_pkg::rsp_t      rsp;
    logic                accept;
    logic                out_free;
    logic                in_range;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = accept;

    // pick the entry to read: allocation target or the requested number
    always_comb begin
        if (s_data.kind == bntt_pkg::KIND_ALLOC) begin
            if (free_head_reg < NULL_PTR) begin
                rd_addr = free_head_reg[IDX_W-1:0];
            end else begin
                rd_addr = nun_reg[IDX_W-1:0];
            end
        end else begin
            rd_addr = IDX_W'(s_data.block_number);
        end
    end

    // table memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // latch the request with its entry address
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= s_data;
            addr_reg <= rd_addr;
        end
    end

    // decode the entry, work out the response and the write-back
    always_comb begin
        cur = rd_data_reg;
        if (32'(addr_reg) < RESERVED_COUNT) begin
            cur.free     = 1'b0;
            cur.has_disk = 1'b0;
        end
        in_range       = 32'(req_reg.block_number) < 32'(nun_reg);
        free_head_next = free_head_reg;
        nun_next       = nun_reg;
        wr_en          = 1'b0;
        wr_data        = cur;

        rsp                  = '0;
        rsp.status           = bntt_pkg::ST_OK;
        rsp.given_number     = req_reg.block_number;

        unique case (req_reg.kind) inside
            bntt_pkg::KIND_ALLOC: begin
                wr_data.free     = 1'b0;
                wr_data.has_disk = 1'b0;
                wr_data.length   = '0;
                rsp.given_number = bntt_pkg::NUM_W'(addr_reg);
                if (free_head_reg < NULL_PTR) begin
                    free_head_next = cur.next_free;
                    wr_en          = 1'b1;
                end else if (nun_reg < NULL_PTR) begin
                    nun_next = nun_reg + PTR_W'(1);
                    wr_en    = 1'b1;
                end else begin
                    rsp.status       = bntt_pkg::ST_FULL;
                    rsp.given_number = '0;
                end
            end
            bntt_pkg::KIND_LOOKUP: begin
                if (!in_range) begin
                    rsp.status = bntt_pkg::ST_INVALID;
                end else if (cur.free) begin
                    rsp.status = bntt_pkg::ST_NOT_ALLOC;
                end else if (cur.has_disk) begin
                    rsp.found_location = cur.offset;
                    rsp.found_length   = cur.length;
                end else begin
                    rsp.found_location = bntt_pkg::NO_DISK_MARK;
                end
            end
            bntt_pkg::KIND_FREE, bntt_pkg::KIND_SET: begin
                if (!in_range || 32'(req_reg.block_number) < RESERVED_COUNT) begin
                    rsp.status = bntt_pkg::ST_INVALID;
                end else if (cur.free) begin
                    rsp.status = bntt_pkg::ST_NOT_ALLOC;
                end else begin
                    wr_en = 1'b1;
                    if (cur.has_disk) begin
                        rsp.release_valid    = 1'b1;
                        rsp.release_location = cur.offset;
                    end
                    if (req_reg.kind == bntt_pkg::KIND_FREE) begin
                        wr_data.free      = 1'b1;
                        wr_data.has_disk  = 1'b0;
                        wr_data.length    = '0;
                        wr_data.next_free = free_head_reg;
                        free_head_next    = PTR_W'(req_reg.block_number);
                    end else begin
                        wr_data.has_disk = 1'b1;
                        wr_data.offset   = req_reg.location;
                        wr_data.length   = req_reg.length;
                    end
                end
            end
            default: begin
                rsp.status = bntt_pkg::ST_INVALID;
            end
        endcase

        // size after the operation, wrapped to the field width
        rsp.table_bytes = bntt_pkg::BYTES_W'(bntt_pkg::BYTES_BASE
                          + (32'(nun_next) << bntt_pkg::BYTES_PER_SHIFT));

        // commit only when the response can be loaded
        if (!(state_reg == S_EXEC && out_free)) begin
            wr_en = 1'b0;
        end
    end

    // sequencer with the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            free_head_reg <= NULL_PTR;
            nun_reg       <= PTR_W'(RESERVED_COUNT);
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (accept) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_data_reg    <= rsp;
                        free_head_reg <= free_head_next;
                        nun_reg       <= nun_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a request in execute completes as soon as the output register frees
    a_exec_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && out_free) |=> (state_reg == S_IDLE && m_valid_reg))
        else $error("execute step did not complete");

    // the never-used count stays between the reserved count and the capacity
    a_nun_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(nun_reg) >= RESERVED_COUNT) && (32'(nun_reg) <= TABLE_ENTRIES))
        else $error("never-used count out of range");

    // a non-empty free list points at an issued, non-reserved number
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg != NULL_PTR) |->
            (free_head_reg < nun_reg && 32'(free_head_reg) >= RESERVED_COUNT))
        else $error("free-list head out of range");

    // the table is written only in the execute step of an accepted request
    a_write_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_EXEC && $past(state_reg) == S_IDLE ||
                   state_reg == S_EXEC && $past(state_reg) == S_EXEC))
        else $error("table write outside execute");

    // an accepted request reads the table and moves to execute
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_EXEC && !s_ready))
        else $error("accepted request did not enter execute");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the block number translation table. A directed
// opening covers reserved numbers, out-of-range numbers, freed entries,
// extreme extents and release on free and set. Random traffic then fills the
// table to the full state and recycles numbers through the free list. Both
// channels stall at random. Every response word is checked field by field
// against an in-order prediction kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ENTRIES      = bntt_pkg::DEF_TABLE_ENTRIES;
    localparam int RESERVED     = bntt_pkg::DEF_RESERVED_COUNT;
    localparam int RANDOM_ITEMS = 1525;
    localparam int QUIET_LIMIT  = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTED  = 100;

    localparam logic [bntt_pkg::OFF_W-1:0] OFF_MAX = '1;
    localparam logic [bntt_pkg::LEN_W-1:0] LEN_MAX = '1;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the table, predicts one response per request
    // ------------------------------------------------------------------------
    class translation_checker;
        bit                         entry_free [ENTRIES];
        bit                         has_extent [ENTRIES];
        logic [bntt_pkg::OFF_W-1:0] extent_off [ENTRIES];
        logic [bntt_pkg::LEN_W-1:0] extent_len [ENTRIES];
        int                         next_free  [ENTRIES];
        int                         free_head;
        int                         never_used;
        bntt_pkg::rsp_t             due_responses [$];
        int                         mismatch_count;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                entry_free[i] = (i >= RESERVED);
                has_extent[i] = 1'b0;
                extent_off[i] = '0;
                extent_len[i] = '0;
                next_free[i]  = 0;
            end
            free_head      = ENTRIES;
            never_used     = RESERVED;
            mismatch_count = 0;
        endfunction

        function int pending();
            return due_responses.size();
        endfunction

        // Work out the response to an accepted request and update the table
        function void note_request(bntt_pkg::req_t w);
            bntt_pkg::rsp_t r;
            int   b;
            int   n;
            bit   got;
            bit   in_range;
            r = '0;
            r.status = bntt_pkg::ST_OK;
            r.given_number = w.block_number;
            b = int'(w.block_number);
            in_range = (b < never_used);
            case (w.kind)
                bntt_pkg::KIND_ALLOC: begin
                    got = 1'b1;
                    n = 0;
                    if (free_head < ENTRIES) begin
                        n = free_head;
                        free_head = next_free[n];
                    end else if (never_used < ENTRIES) begin
                        n = never_used;
                        never_used++;
                    end else begin
                        got = 1'b0;
                    end
                    if (got) begin
                        entry_free[n] = 1'b0;
                        has_extent[n] = 1'b0;
                        extent_len[n] = '0;
                        r.given_number = bntt_pkg::NUM_W'(n);
                    end else begin
                        r.status = bntt_pkg::ST_FULL;
                        r.given_number = '0;
                    end
                end
                bntt_pkg::KIND_LOOKUP: begin
                    if (!in_range) begin
                        r.status = bntt_pkg::ST_INVALID;
                    end else if (entry_free[b]) begin
                        r.status = bntt_pkg::ST_NOT_ALLOC;
                    end else if (has_extent[b]) begin
                        r.found_location = extent_off[b];
                        r.found_length = extent_len[b];
                    end else begin
                        r.found_location = bntt_pkg::NO_DISK_MARK;
                    end
                end
                default: begin
                    // free and set location share the checks and the release
                    if (!in_range || b < RESERVED) begin
                        r.status = bntt_pkg::ST_INVALID;
                    end else if (entry_free[b]) begin
                        r.status = bntt_pkg::ST_NOT_ALLOC;
                    end else begin
                        if (has_extent[b]) begin
                            r.release_valid = 1'b1;
                            r.release_location = extent_off[b];
                        end
                        if (w.kind == bntt_pkg::KIND_FREE) begin
                            entry_free[b] = 1'b1;
                            has_extent[b] = 1'b0;
                            extent_len[b] = '0;
                            next_free[b] = free_head;
                            free_head = b;
                        end else begin
                            has_extent[b] = 1'b1;
                            extent_off[b] = w.location;
                            extent_len[b] = w.length;
                        end
                    end
                end
            endcase
            r.table_bytes = bntt_pkg::BYTES_W'(bntt_pkg::BYTES_BASE
                            + (never_used << bntt_pkg::BYTES_PER_SHIFT));
            due_responses.push_back(r);
        endfunction

        task report(string what);
            mismatch_count++;
            // keep the log short when the block is badly broken
            if (mismatch_count <= MAX_PRINTED) begin
                $display("%0t mismatch: %s", $time, what);
            end
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report($sformatf("%s got %0h want %0h", name, got, want));
            end
        endtask

        // Check an accepted response word against the oldest prediction
        task check_response(bntt_pkg::rsp_t got);
            bntt_pkg::rsp_t want;
            if (due_responses.size() == 0) begin
                report("response word with none outstanding");
            end else begin
                want = due_responses.pop_front();
                compare_field("status", 64'(got.status), 64'(want.status));
                compare_field("given_number", 64'(got.given_number),
                              64'(want.given_number));
                compare_field("found_location", 64'(got.found_location),
                              64'(want.found_location));
                compare_field("found_length", 64'(got.found_length),
                              64'(want.found_length));
                compare_field("release_valid", 64'(got.release_valid),
                              64'(want.release_valid));
                compare_field("release_location", 64'(got.release_location),
                              64'(want.release_location));
                compare_field("table_bytes", 64'(got.table_bytes),
                              64'(want.table_bytes));
            end
        endtask
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    bntt_pkg::req_t s_data;
    logic m_valid;
    logic m_ready;
    bntt_pkg::rsp_t m_data;

    translation_checker tables;
    bit no_idle;
    int quiet_cycles = 0;

    block_number_translation_table #(
        .TABLE_ENTRIES (ENTRIES),
        .RESERVED_COUNT(RESERVED)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle cycles before each word; none during a burst stretch
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic bntt_pkg::req_t make_request(bntt_pkg::kind_t k, int num,
                                                    logic [bntt_pkg::OFF_W-1:0] loc,
                                                    logic [bntt_pkg::LEN_W-1:0] len);
        bntt_pkg::req_t w;
        w.kind = k;
        w.block_number = bntt_pkg::NUM_W'(num);
        w.location = loc;
        w.length = len;
        return w;
    endfunction

    // Mostly numbers that are currently allocated, some reserved, some anything
    function automatic int pick_number();
        int sel;
        int n;
        int tries;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            n = $urandom_range(RESERVED, tables.never_used - 1);
            tries = 0;
            while (tables.entry_free[n] && tries < 8) begin
                n = $urandom_range(RESERVED, tables.never_used - 1);
                tries++;
            end
        end else if (sel < 90) begin
            n = $urandom_range(0, RESERVED - 1);
        end else begin
            n = $urandom_range(0, (1 << bntt_pkg::NUM_W) - 1);
        end
        return n;
    endfunction

    // Allocate-heavy until every number has been issued, then an even mix
    function automatic bntt_pkg::req_t random_request();
        bntt_pkg::req_t  w;
        int              sel;
        bntt_pkg::kind_t k;
        sel = $urandom_range(0, 99);
        if (tables.never_used < ENTRIES) begin
            k = (sel < 80) ? bntt_pkg::KIND_ALLOC : (sel < 86) ? bntt_pkg::KIND_FREE :
                (sel < 93) ? bntt_pkg::KIND_LOOKUP : bntt_pkg::KIND_SET;
        end else begin
            k = (sel < 25) ? bntt_pkg::KIND_ALLOC : (sel < 50) ? bntt_pkg::KIND_FREE :
                (sel < 75) ? bntt_pkg::KIND_LOOKUP : bntt_pkg::KIND_SET;
        end
        w = make_request(k, pick_number(), bntt_pkg::OFF_W'({$urandom, $urandom}),
                         bntt_pkg::LEN_W'($urandom));
        return w;
    endfunction

    // Offer one request word and hold it until accepted
    task automatic send_request(bntt_pkg::req_t w);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tables.note_request(w);
    endtask

    // Drop valid and hold off until every response has come back
    task automatic wait_quiet();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tables.pending() != 0);
    endtask

    // Stimulus
    initial begin
        int i;
        tables = new();
        no_idle = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reserved and out-of-range numbers
        send_request(make_request(bntt_pkg::KIND_LOOKUP, 0, '0, '0));
        send_request(make_request(bntt_pkg::KIND_LOOKUP, RESERVED, '0, '0));
        send_request(make_request(bntt_pkg::KIND_FREE, 1, '0, '0));
        send_request(make_request(bntt_pkg::KIND_SET, RESERVED - 1, OFF_MAX, LEN_MAX));
        // fresh numbers, extreme extents, release on set and on free
        send_request(make_request(bntt_pkg::KIND_ALLOC, 0, '0, '0));
        send_request(make_request(bntt_pkg::KIND_ALLOC, 1023, OFF_MAX, LEN_MAX));
        send_request(make_request(bntt_pkg::KIND_LOOKUP, RESERVED, '0, '0));
        send_request(make_request(bntt_pkg::KIND_SET, RESERVED, OFF_MAX, LEN_MAX));
        send_request(make_request(bntt_pkg::KIND_LOOKUP, RESERVED, '0, '0));
        send_request(make_request(bntt_pkg::KIND_SET, RESERVED, '0, '0));
        send_request(make_request(bntt_pkg::KIND_FREE, RESERVED, '0, '0));
        // operations on a freed number, then freeing a second number
        send_request(make_request(bntt_pkg::KIND_FREE, RESERVED, '0, '0));
        send_request(make_request(bntt_pkg::KIND_LOOKUP, RESERVED, '0, '0));
        send_request(make_request(bntt_pkg::KIND_SET, RESERVED, OFF_MAX, '0));
        send_request(make_request(bntt_pkg::KIND_FREE, RESERVED + 1, '0, '0));
        // reuse from the free list, then a never-used number
        send_request(make_request(bntt_pkg::KIND_ALLOC, 0, '0, '0));
        send_request(make_request(bntt_pkg::KIND_ALLOC, 0, '0, '0));
        send_request(make_request(bntt_pkg::KIND_ALLOC, 0, '0, '0));
        send_request(make_request(bntt_pkg::KIND_LOOKUP, 1023, '0, '0));
        send_request(make_request(bntt_pkg::KIND_SET, 1023, '0, LEN_MAX));
        send_request(make_request(bntt_pkg::KIND_SET, RESERVED + 2,
                                  48'h0000_0000_0001, 32'h1));
        send_request(make_request(bntt_pkg::KIND_FREE, RESERVED + 2, '0, '0));
        send_request(make_request(bntt_pkg::KIND_LOOKUP, RESERVED + 1, '0, '0));

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (i % 300 == 150) begin
                wait_quiet();
            end
            send_request(random_request());
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tables.mismatch_count == 0) begin
            $display("block_number_translation_table regression: pass");
        end else begin
            $display("block_number_translation_table regression: fail");
        end
        $finish;
    end

    // Response side: stall at random, check each accepted word
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            tables.check_response(m_data);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("block_number_translation_table regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
